// ===== rtl/alpl_pkg.sv =====
// ----------------------------------------------------------------------------
// alpl_pkg
// Shared types, codes and widths for the arc length parameter lookup.
// ----------------------------------------------------------------------------
package alpl_pkg;

    localparam int unsigned MAX_SAMPLES_DEF = 4096;

    localparam int unsigned U_W     = 17;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned OFF_W   = 25;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IW  = 3;
    localparam int unsigned PROD_W  = U_W + DIST_W;
    localparam int unsigned DEN_W   = PROD_W;
    localparam int unsigned REM_W   = DEN_W + 1;
    localparam int unsigned NUM_W   = PROD_W + 2;

    localparam logic [U_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_IW-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_REVERSE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_OFFSET  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_STATIC  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_COUNT   = 3'd4;

    localparam logic [1:0] MODE_PARAM   = 2'd0;
    localparam logic [1:0] MODE_PERCENT = 2'd1;
    localparam logic [1:0] MODE_FIXED   = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [DIST_W-1:0] entry_distance;
        logic [U_W-1:0]    u_in;
        logic [U_W-1:0]    v_in;
    } t_item;

    typedef struct packed {
        logic [U_W-1:0] u_out;
        logic [U_W-1:0] v_out;
        logic [1:0]     status;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [U_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/arc_length_param_lookup.sv =====
// ----------------------------------------------------------------------------
// arc_length_param_lookup
// Maps a u parameter to an arc length parameter; in the length modes through
// a table of cumulative lengths, by binary search and linear interpolation.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start & !busy             i_item (t_item)
// result    out        o_strobe, one cycle       o_result (t_result)
// config    in         i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// A load or a parametric query leaves busy low; a parametric result strobes in
// the cycle after acceptance. A length-mode query holds busy through the binary
// search (about log2(n) steps, one table read per step on the single read port),
// the interpolation and the serial divider. A flat segment skips the multiply
// and range check; a saturation found before the divide skips the divider.
// The result strobes in the first idle cycle. Reset clears control and
// configuration; the table is undefined until written. The receiver cannot
// stall; busy holds off new commands.
// ----------------------------------------------------------------------------
module arc_length_param_lookup
    import alpl_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_strobe,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TOT  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;

    logic [1:0]        r_mode;
    logic              r_rev;
    logic [OFF_W-1:0]  r_off;
    logic [DIST_W-1:0] r_static;
    logic [CNT_W-1:0]  r_count;

    logic [DIST_W-1:0] mem [MAX_SAMPLES];
    logic [DIST_W-1:0] r_rdata;

    logic [3:0]        r_state;
    logic [U_W-1:0]    r_p;
    logic [U_W-1:0]    r_v;
    logic [NW-1:0]     r_n;
    logic [DIST_W-1:0] r_target;
    logic [AW-1:0]     r_lo;
    logic [AW-1:0]     r_hi;
    logic [AW-1:0]     r_c;
    logic [DIST_W-1:0] r_da;
    logic [DIST_W-1:0] r_den;
    logic [PROD_W-1:0] r_prod;
    logic [DEN_W-1:0]  r_dd;
    logic [NUM_W-1:0]  r_num;
    logic [1:0]        r_st;
    logic              r_strobe;
    t_result           r_result;

    logic              w_accept;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [NW-1:0]     w_n;
    logic [U_W-1:0]    w_p;
    logic [U_W-1:0]    w_mul_a;
    logic [DIST_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [DIST_W-1:0] w_scale;
    logic [AW-1:0]     w_mid;
    logic [AW:0]       w_mid_sum;
    logic [AW-1:0]     w_nlo;
    logic [AW-1:0]     w_nhi;
    logic              w_found;
    logic [U_W-1:0]    w_c1;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PARAM;
            r_rev    <= 1'b0;
            r_off    <= '0;
            r_static <= 32'd7;
            r_count  <= 13'd2048;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode   <= i_cfg_wdata[1:0];
                CFG_REVERSE: r_rev    <= i_cfg_wdata[0];
                CFG_OFFSET:  r_off    <= i_cfg_wdata[OFF_W-1:0];
                CFG_STATIC:  r_static <= i_cfg_wdata;
                CFG_COUNT:   r_count  <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---- entry count clamp ----
    always_comb begin
        if (r_count < 13'd2) begin
            w_n = NW'(2);
        end else if (32'(r_count) > 32'(MAX_SAMPLES)) begin
            w_n = NW'(MAX_SAMPLES);
        end else begin
            w_n = NW'(r_count);
        end
    end

    // ---- offset wrap and mirror ----
    always_comb begin
        logic signed [26:0] sum;
        logic signed [26:0] neg;
        logic [U_W-1:0]     p;
        sum = $signed({10'b0, i_item.u_in}) + 27'(signed'(r_off));
        neg = -sum;
        if (!sum[26]) begin
            p = {1'b0, sum[15:0]};
        end else begin
            p = ONE_Q16 - {1'b0, neg[15:0]};
        end
        if (i_item.u_in == ONE_Q16 && p == '0) begin
            p = ONE_Q16;
        end
        if (r_rev) begin
            p = ONE_Q16 - p;
        end
        w_p = p;
    end

    assign busy     = r_state != S_IDLE;
    assign w_accept = start && !busy;
    assign w_we     = w_accept && i_item.cmd == CMD_LOAD &&
                      32'(i_item.entry_index) < 32'(MAX_SAMPLES);
    assign w_waddr  = AW'(32'(i_item.entry_index));

    // ---- shared multiplier ----
    assign w_scale = (r_mode == MODE_FIXED && r_static < r_rdata) ? r_static : r_rdata;
    assign w_c1    = U_W'(r_c) + U_W'(1);

    always_comb begin
        unique case (r_state)
            S_TOT: begin
                w_mul_a = r_p;
                w_mul_b = w_scale;
            end
            S_MUL1: begin
                w_mul_a = w_c1;
                w_mul_b = r_den;
            end
            default: begin
                w_mul_a = U_W'(r_n);
                w_mul_b = r_den;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // ---- binary search step ----
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[AW:1];
    assign w_found   = (r_rdata == r_target) || (r_hi - r_lo == AW'(1));

    always_comb begin
        w_nlo = r_lo;
        w_nhi = r_hi;
        if (r_rdata < r_target) begin
            w_nlo = w_mid;
        end else begin
            w_nhi = w_mid;
        end
    end

    // ---- read address ----
    always_comb begin
        logic [AW:0] ms;
        logic [AW-1:0] top;
        top = AW'(r_n - NW'(1));
        ms  = {1'b0, w_nlo} + {1'b0, w_nhi};
        unique case (r_state)
            S_IDLE: w_raddr = AW'(w_n - NW'(1));
            S_TOT:  w_raddr = top >> 1;
            S_SCMP: begin
                if (!w_found) begin
                    w_raddr = ms[AW:1];
                end else if (r_rdata == r_target) begin
                    w_raddr = w_mid;
                end else begin
                    w_raddr = r_lo;
                end
            end
            S_RDA:  w_raddr = r_c + AW'(1);
            default: w_raddr = r_c;
        endcase
    end

    // ---- length table ----
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_item.entry_distance;
        end
        r_rdata <= mem[w_raddr];
    end

    // ---- divider ----
    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = r_num[REM_W-1:0];
        w_req.den   = r_dd;
        if (r_state == S_RDB && r_rdata <= r_da) begin
            w_req.start = 1'b1;
            w_req.num   = REM_W'(w_c1);
            w_req.den   = DEN_W'(r_n);
        end else if (r_state == S_CHK && !r_num[NUM_W-1] &&
                     r_num[REM_W-1:0] < {r_dd, 1'b0}) begin
            w_req.start = 1'b1;
        end
    end

    alpl_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_item.cmd == CMD_QUERY) begin
                        if (r_mode == MODE_PARAM) begin
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_TOT;
                        end
                    end
                end
                S_TOT: r_state <= S_SCMP;
                S_SCMP: begin
                    if (w_found) begin
                        r_state <= S_RDA;
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: r_state <= (r_rdata <= r_da) ? S_DIV : S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_CHK;
                S_CHK: begin
                    if (r_num[NUM_W-1] || r_num[REM_W-1:0] >= {r_dd, 1'b0}) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_p  <= w_p;
                r_v  <= i_item.v_in;
                r_n  <= w_n;
                r_st <= ST_OK;
                r_result <= '{u_out: w_p, v_out: i_item.v_in, status: ST_OK};
            end
            S_TOT: begin
                r_target <= w_prod[DIST_W+15:16];
                r_lo     <= '0;
                r_hi     <= AW'(r_n - NW'(1));
            end
            S_SCMP: begin
                r_lo <= w_nlo;
                r_hi <= w_nhi;
                r_c  <= (r_rdata == r_target) ? w_mid : r_lo;
            end
            S_RDA: r_da <= r_rdata;
            S_RDB: begin
                r_den <= r_rdata - r_da;
                r_st  <= (r_rdata <= r_da) ? ST_ZERO : ST_OK;
            end
            S_MUL1: r_prod <= w_prod;
            S_MUL2: begin
                r_dd  <= w_prod;
                r_num <= NUM_W'(r_prod) + NUM_W'(r_target) - NUM_W'(r_da);
            end
            S_CHK: begin
                if (r_num[NUM_W-1]) begin
                    r_result <= '{u_out: '0, v_out: r_v, status: ST_SAT};
                end else begin
                    r_result <= '{u_out: ONE_Q16, v_out: r_v, status: ST_SAT};
                end
            end
            S_DIV: begin
                if (w_rsp.quot > ONE_Q16) begin
                    r_result <= '{u_out: ONE_Q16, v_out: r_v, status: ST_SAT};
                end else begin
                    r_result <= '{u_out: w_rsp.quot, v_out: r_v, status: r_st};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.u_out <= ONE_Q16)
        else $error("result u beyond one");

    a_sat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_SAT) |->
        (o_result.u_out == '0 || o_result.u_out == ONE_Q16))
        else $error("saturated result not at a bound");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCMP |-> r_lo < r_hi)
        else $error("search bounds crossed");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");

endmodule

// ===== rtl/alpl_divider.sv =====
// ----------------------------------------------------------------------------
// alpl_divider
// Restoring divider, one quotient bit per cycle: floor(num * 65536 / den)
// for num below twice den.
// ----------------------------------------------------------------------------
module alpl_divider
    import alpl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_den;
    logic [U_W-1:0]   r_q;
    logic [4:0]       r_cnt;
    logic             r_run;
    logic             r_done;

    logic             w_ge;
    logic [REM_W-1:0] w_sub;

    assign w_ge  = r_rem >= r_den;
    assign w_sub = w_ge ? r_rem - r_den : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= 5'(U_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= {1'b0, i_req.den};
            r_q   <= '0;
        end else if (r_run) begin
            r_rem <= {w_sub[REM_W-2:0], 1'b0};
            r_q   <= {r_q[U_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run))
        else $error("divider done without a running division");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the arc length parameter lookup. Each phase sets up
// the registers while the block is idle. For the length modes it loads a
// cumulative length table; it runs queries mixed with stray loads. A behavioral
// predictor computes the result of every accepted query. The monitor compares
// each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import alpl_pkg::*;

    localparam int unsigned TBL_DEPTH   = 4096;
    localparam int unsigned DRAIN_WAIT  = 80;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_item             i_item = '0;
    logic              o_strobe;
    t_result           o_result;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    arc_length_param_lookup DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the block's state
    logic [1:0]        cfg_mode   = MODE_PARAM;
    logic              cfg_rev    = 1'b0;
    logic [OFF_W-1:0]  cfg_off    = '0;
    logic [DIST_W-1:0] cfg_static = 32'd7;
    logic [CNT_W-1:0]  cfg_cnt    = 13'd2048;
    logic [DIST_W-1:0] len_mem [TBL_DEPTH];

    t_item   pending_items [$];
    t_result expected_params [$];
    int      mismatches = 0;
    int      items_taken = 0;
    int      gap_left = 0;
    bit      no_idle = 1'b0;
    logic    taken = 1'b0;
    longint  cycles = 0;

    function automatic int unsigned entries_used();
        if (cfg_cnt < 2) return 2;
        if (cfg_cnt > TBL_DEPTH) return TBL_DEPTH;
        return cfg_cnt;
    endfunction

    function automatic t_result predict_lookup(t_item it);
        longint            sum, num, den;
        longint unsigned   wrap, target, q, dividend, divisor;
        int unsigned       p, n, c, lo, hi, mid;
        logic [DIST_W-1:0] total, scale, dist_a, dist_b;
        t_result           r;
        sum = longint'(it.u_in) + longint'($signed(cfg_off));
        if (sum >= 0) begin
            p = 32'(sum[15:0]);
        end else begin
            wrap = 65536 - sum;
            p = 65536 - wrap[15:0];
        end
        if (it.u_in == ONE_Q16 && p == 0) p = 65536;
        if (cfg_rev) p = 65536 - p;
        r.status = ST_OK;
        if (cfg_mode != MODE_PARAM) begin
            n = entries_used();
            total = len_mem[n-1];
            scale = total;
            if (cfg_mode == MODE_FIXED && cfg_static < total) scale = cfg_static;
            target = (longint'(scale) * p) >> 16;
            lo = 0;
            hi = n - 1;
            c = 0;
            forever begin
                mid = (lo + hi) / 2;
                if (len_mem[mid] == target) begin
                    c = mid;
                    break;
                end
                if (hi - lo == 1) begin
                    c = lo;
                    break;
                end
                if (len_mem[mid] < target) lo = mid;
                else hi = mid;
            end
            dist_a = len_mem[c];
            dist_b = len_mem[c+1];
            if (dist_b <= dist_a) begin
                p = 32'((longint'(c + 1) * 65536) / n);
                r.status = ST_ZERO;
            end else begin
                den = longint'(dist_b) - longint'(dist_a);
                num = longint'(c + 1) * den + (longint'(target) - longint'(dist_a));
                if (num < 0) begin
                    p = 0;
                    r.status = ST_SAT;
                end else begin
                    dividend = num;
                    divisor = den;
                    q = (dividend * 65536) / (divisor * n);
                    if (q > 65536) begin
                        p = 65536;
                        r.status = ST_SAT;
                    end else begin
                        p = 32'(q);
                    end
                end
            end
        end
        r.u_out = p[U_W-1:0];
        r.v_out = it.v_in;
        return r;
    endfunction

    function automatic t_item load_item(int unsigned idx, logic [DIST_W-1:0] dist_v);
        t_item it;
        it.cmd = CMD_LOAD;
        it.entry_index = idx[IDX_W-1:0];
        it.entry_distance = dist_v;
        it.u_in = U_W'($urandom);
        it.v_in = U_W'($urandom);
        return it;
    endfunction

    function automatic t_item query_item(logic [U_W-1:0] u, logic [U_W-1:0] v);
        t_item it;
        it.cmd = CMD_QUERY;
        it.entry_index = IDX_W'($urandom);
        it.entry_distance = $urandom;
        it.u_in = u;
        it.v_in = v;
        return it;
    endfunction

    function automatic logic [U_W-1:0] random_u();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return ONE_Q16;
            2: return 17'h1FFFF;
            3: return U_W'($urandom_range(65537, 131071));
            default: return U_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // accepted transactions feed the predictor
    always @(posedge i_clk) begin
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            items_taken++;
            if (i_item.cmd == CMD_QUERY) expected_params.push_back(predict_lookup(i_item));
            else len_mem[i_item.entry_index] = i_item.entry_distance;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_params.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result u=%0d v=%0d status=%0d",
                             o_result.u_out, o_result.v_out, o_result.status);
            end else begin
                exp_r = expected_params.pop_front();
                if (o_result !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected u=%0d v=%0d status=%0d, got u=%0d v=%0d status=%0d",
                                 exp_r.u_out, exp_r.v_out, exp_r.status,
                                 o_result.u_out, o_result.v_out, o_result.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** arc_length_param_lookup: FAILED **");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || start || gap_left != 0 ||
               expected_params.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_MODE:    cfg_mode = data[1:0];
            CFG_REVERSE: cfg_rev = data[0];
            CFG_OFFSET:  cfg_off = data[OFF_W-1:0];
            CFG_STATIC:  cfg_static = data;
            CFG_COUNT:   cfg_cnt = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [1:0] md, logic rev, logic [OFF_W-1:0] off,
                         logic [DIST_W-1:0] stat, logic [CNT_W-1:0] cnt);
        write_cfg(CFG_MODE, CFG_W'(md));
        write_cfg(CFG_REVERSE, CFG_W'(rev));
        write_cfg(CFG_OFFSET, CFG_W'(off));
        write_cfg(CFG_STATIC, stat);
        write_cfg(CFG_COUNT, CFG_W'(cnt));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_table(bit flat_runs);
        logic [DIST_W-1:0] dist_v, step_max;
        int unsigned n;
        n = entries_used();
        step_max = 32'hFFFFFFFF / n;
        dist_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, step_max) : 32'd0;
        for (int unsigned i = 0; i < n; i++) begin
            pending_items.push_back(load_item(i, dist_v));
            if (!(flat_runs && $urandom_range(0, 3) == 0))
                dist_v = dist_v + $urandom_range(1, step_max);
        end
    endtask

    task automatic run_queries(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(load_item($urandom_range(entries_used(), 4095),
                                                  $urandom));
            pending_items.push_back(query_item(random_u(), U_W'($urandom_range(0, 131071))));
        end
    endtask

    function automatic logic [CNT_W-1:0] random_count();
        case ($urandom_range(0, 19))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'h1FFF;
            3: return 13'd2;
            default: return CNT_W'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] random_offset();
        case ($urandom_range(0, 7))
            0: return 25'h1000000;
            1: return 25'h0FFFFFF;
            2: return 25'd0;
            3: return OFF_W'($urandom);
            default: return OFF_W'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    initial begin
        logic [1:0]       md;
        logic [CNT_W-1:0] cnt;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // parametric mode with offset extremes and the input of one
        setup(MODE_PARAM, 1'b0, 25'd0, 32'd7, 13'd2048);
        pending_items.push_back(query_item(17'd0, 17'd0));
        pending_items.push_back(query_item(ONE_Q16, ONE_Q16));
        pending_items.push_back(query_item(17'h1FFFF, 17'h1FFFF));
        pending_items.push_back(query_item(17'h08000, 17'h0ABCD));
        wait_idle();
        setup(MODE_PARAM, 1'b1, 25'h1000000, 32'd0, 13'd2);
        pending_items.push_back(query_item(17'd0, 17'd1));
        pending_items.push_back(query_item(ONE_Q16, 17'd2));
        pending_items.push_back(query_item(17'h1FFFF, 17'd3));
        wait_idle();
        setup(MODE_PARAM, 1'b0, 25'h0FFFFFF, 32'hFFFFFFFF, 13'd2);
        pending_items.push_back(query_item(17'd0, 17'd4));
        pending_items.push_back(query_item(ONE_Q16, 17'd5));
        pending_items.push_back(query_item(17'd1, 17'd6));
        wait_idle();

        // percentage mode, flat segment and saturation below the first entry, then fixed mode
        setup(MODE_PERCENT, 1'b0, 25'd0, 32'd7, 13'd2);
        pending_items.push_back(load_item(0, 32'd50000));
        pending_items.push_back(load_item(1, 32'd50000));
        pending_items.push_back(query_item(17'd0, 17'd7));
        pending_items.push_back(query_item(ONE_Q16, 17'd8));
        pending_items.push_back(load_item(1, 32'd50100));
        pending_items.push_back(query_item(17'd0, 17'd9));
        pending_items.push_back(query_item(ONE_Q16, 17'd10));
        pending_items.push_back(load_item(4095, 32'hFFFFFFFF));
        wait_idle();
        setup(MODE_FIXED, 1'b1, 25'd0, 32'd7, 13'd4);
        fill_table(1'b1);
        run_queries(4);
        wait_idle();

        // one pass over a large table
        no_idle = 1'b1;
        setup(MODE_PERCENT, 1'b0, random_offset(), $urandom, 13'd256);
        fill_table(1'b1);
        run_queries(40);
        wait_idle();
        no_idle = 1'b0;

        while (items_taken < 1200) begin
            no_idle = ($urandom_range(0, 5) == 0);
            cnt = random_count();
            md = 2'($urandom_range(0, 3));
            if (cnt > 13'd24) md = MODE_PARAM;
            setup(md, 1'($urandom_range(0, 1)), random_offset(),
                  ($urandom_range(0, 3) == 0) ? 32'd7 : 32'($urandom), cnt);
            if (cfg_mode != MODE_PARAM) fill_table(1'($urandom_range(0, 1)));
            run_queries($urandom_range(10, 50));
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("** arc_length_param_lookup: PASSED **");
        end else begin
            $display("** arc_length_param_lookup: FAILED **");
        end
        $finish;
    end

endmodule

// ===== arc_length_param_lookup.f =====
rtl/alpl_pkg.sv
rtl/alpl_divider.sv
rtl/arc_length_param_lookup.sv
verif/tb_top.sv
